### rtl/core/eca_pkg.sv
// shared types and operation codes for the execute stage
`default_nettype none

package eca_pkg;

  typedef enum logic [4:0] {
    FN_NOP  = 5'd0,
    FN_LD   = 5'd1,
    FN_LDR  = 5'd2,
    FN_ST   = 5'd3,
    FN_ADDA = 5'd4,
    FN_ADDL = 5'd5,
    FN_SUBA = 5'd6,
    FN_SUBL = 5'd7,
    FN_AND  = 5'd8,
    FN_OR   = 5'd9,
    FN_XOR  = 5'd10,
    FN_CPA  = 5'd11,
    FN_CPL  = 5'd12,
    FN_SLA  = 5'd13,
    FN_SLL  = 5'd14,
    FN_SRA  = 5'd15,
    FN_SRL  = 5'd16,
    FN_JUMP = 5'd17,
    FN_JPL  = 5'd18,
    FN_JMI  = 5'd19,
    FN_JNZ  = 5'd20,
    FN_JZE  = 5'd21,
    FN_JOV  = 5'd22,
    FN_POP  = 5'd23
  } func_t;

  localparam int unsigned DataW   = 16;
  localparam int unsigned RegSelW = 3;
  localparam int unsigned NumRegs = 8;
  localparam logic [7:0]  ShMax   = 8'd16;

  typedef struct packed {
    logic [4:0]         func;
    logic [RegSelW-1:0] reg_sel;
    logic [RegSelW-1:0] src_sel;
    logic [DataW-1:0]   operand;
  } op_word_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic             reg_written;
    logic             jump_taken;
    logic             overflow_flag;
    logic             sign_flag;
    logic             zero_flag;
  } res_word_t;

  typedef struct packed {
    logic of;
    logic sf;
    logic zf;
  } flags_t;

endpackage

`default_nettype wire

### rtl/core/eca_regs.sv
// general register file, two registered read ports with write bypass
`default_nettype none

module eca_regs
  import eca_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               rd_en,
  input  wire logic [RegSelW-1:0] rd_addr_a,
  input  wire logic [RegSelW-1:0] rd_addr_b,
  output logic      [DataW-1:0]   rd_data_a,
  output logic      [DataW-1:0]   rd_data_b,
  input  wire logic               wr_en,
  input  wire logic [RegSelW-1:0] wr_addr,
  input  wire logic [DataW-1:0]   wr_data
);

  logic [DataW-1:0]   mem [NumRegs];
  logic [NumRegs-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && wr_addr == rd_addr_a) begin
        rd_data_a <= wr_data;
      end else if (valid[rd_addr_a]) begin
        rd_data_a <= mem[rd_addr_a];
      end else begin
        rd_data_a <= '0;
      end
      if (wr_en && wr_addr == rd_addr_b) begin
        rd_data_b <= wr_data;
      end else if (valid[rd_addr_b]) begin
        rd_data_b <= mem[rd_addr_b];
      end else begin
        rd_data_b <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_valid_after_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> valid[$past(wr_addr)])
    else $error("written register not marked valid");
  a_bypass_a: assert property (@(posedge clk) disable iff (rst)
    rd_en && wr_en && wr_addr == rd_addr_a |=> rd_data_a == $past(wr_data))
    else $error("read port a missed write bypass");
  a_reset_clears: assert property (@(posedge clk)
    rst |=> valid == '0)
    else $error("register valid bits not cleared by reset");
`endif

endmodule

`default_nettype wire

### rtl/core/eca_alu.sv
// operation decode, arithmetic, logic, shifts, compares and jump decisions
`default_nettype none

module eca_alu
  import eca_pkg::*;
(
  input  wire logic [4:0]       func,
  input  wire logic [DataW-1:0] a,
  input  wire logic [DataW-1:0] b,
  input  wire logic [DataW-1:0] operand,
  input  wire flags_t           flags,
  output res_word_t             res,
  output flags_t                flags_next
);

  logic [DataW:0]          sum;
  logic [DataW:0]          diff;
  logic [4:0]              sh_cnt;
  logic [2*DataW-1:0]      sh_wide;
  logic signed [DataW-1:0] sra_v;
  logic [DataW-1:0]        srl_v;
  logic                    add_ovf;
  logic                    sub_ovf;
  logic [DataW-1:0]        val;
  logic                    wr;
  logic                    jmp;
  logic                    val_flags;
  logic                    val_of;

  always_comb begin
    sum     = {1'b0, a} + {1'b0, operand};
    diff    = {1'b0, a} - {1'b0, operand};
    sh_cnt  = (operand[7:0] > ShMax) ? ShMax[4:0] : operand[4:0];
    sh_wide = {{DataW{1'b0}}, a} << sh_cnt;
    sra_v   = $signed(a) >>> sh_cnt;
    srl_v   = a >> sh_cnt;
    add_ovf = (a[DataW-1] == operand[DataW-1]) && (sum[DataW-1] != a[DataW-1]);
    sub_ovf = (a[DataW-1] != operand[DataW-1]) && (diff[DataW-1] != a[DataW-1]);
  end

  always_comb begin
    val        = '0;
    wr         = 1'b0;
    jmp        = 1'b0;
    val_flags  = 1'b0;
    val_of     = 1'b0;
    flags_next = flags;
    unique case (func)
      FN_LD: begin
        val = operand; wr = 1'b1; val_flags = 1'b1;
      end
      FN_LDR: begin
        val = b; wr = 1'b1; val_flags = 1'b1;
      end
      FN_ST: begin
        val = a;
      end
      FN_ADDA: begin
        val = sum[DataW-1:0]; wr = 1'b1; val_flags = 1'b1; val_of = add_ovf;
      end
      FN_ADDL: begin
        val = sum[DataW-1:0]; wr = 1'b1; val_flags = 1'b1; val_of = sum[DataW];
      end
      FN_SUBA: begin
        val = diff[DataW-1:0]; wr = 1'b1; val_flags = 1'b1; val_of = sub_ovf;
      end
      FN_SUBL: begin
        val = diff[DataW-1:0]; wr = 1'b1; val_flags = 1'b1; val_of = diff[DataW];
      end
      FN_AND: begin
        val = a & operand; wr = 1'b1; val_flags = 1'b1;
      end
      FN_OR: begin
        val = a | operand; wr = 1'b1; val_flags = 1'b1;
      end
      FN_XOR: begin
        val = a ^ operand; wr = 1'b1; val_flags = 1'b1;
      end
      FN_CPA: begin
        flags_next.zf = (a == operand);
        flags_next.sf = ($signed(a) < $signed(operand));
        flags_next.of = sub_ovf;
      end
      FN_CPL: begin
        flags_next.zf = (a == operand);
        flags_next.sf = (a < operand);
        flags_next.of = 1'b0;
      end
      FN_SLA: begin
        val = {a[DataW-1], sh_wide[DataW-2:0]}; wr = 1'b1; val_flags = 1'b1;
      end
      FN_SLL: begin
        val = sh_wide[DataW-1:0]; wr = 1'b1; val_flags = 1'b1;
      end
      FN_SRA: begin
        val = sra_v; wr = 1'b1; val_flags = 1'b1;
      end
      FN_SRL: begin
        val = srl_v; wr = 1'b1; val_flags = 1'b1;
      end
      FN_JUMP: jmp = 1'b1;
      FN_JPL:  jmp = !flags.sf && !flags.zf;
      FN_JMI:  jmp = flags.sf;
      FN_JNZ:  jmp = !flags.zf;
      FN_JZE:  jmp = flags.zf;
      FN_JOV:  jmp = flags.of;
      FN_POP: begin
        val = operand; wr = 1'b1;
      end
      default: begin
        val = '0;
      end
    endcase
    if (val_flags) begin
      flags_next.of = val_of;
      flags_next.sf = val[DataW-1];
      flags_next.zf = (val == '0);
    end
    res.result        = val;
    res.reg_written   = wr;
    res.jump_taken    = jmp;
    res.overflow_flag = flags_next.of;
    res.sign_flag     = flags_next.sf;
    res.zero_flag     = flags_next.zf;
  end

endmodule

`default_nettype wire

### rtl/core/educational_cpu_execute_stage_top.sv
// execute stage top: operand stage, register file, alu and result register
//
// channel  signals                       word
// op       op_valid  op_ready  op_word   func, reg_sel, src_sel, operand
// res      res_valid res_ready res_word  result, reg_written, jump_taken, flags
//
// one word per cycle sustained while res is not stalled; an accepted word passes the operand stage, then res
// the accepting edge captures the word and its register reads; the alu then runs on them,
// and the edge that advances the operand stage writes back into the register file and flags and loads res
// writeback and the next word's register read share one edge, bypassed in the file
// reset clears the registers and flags at once; no warm-up cycles
// a stalled res side holds the result register, then the operand stage, then op_ready
`default_nettype none

module educational_cpu_execute_stage_top
  import eca_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      op_valid,
  output logic           op_ready,
  input  wire op_word_t  op_word,
  output logic           res_valid,
  input  wire logic      res_ready,
  output res_word_t      res_word
);

  logic             exe_valid;
  op_word_t         exe_word;
  logic             exe_advance;
  logic             op_accept;
  logic [DataW-1:0] reg_a;
  logic [DataW-1:0] reg_b;
  flags_t           flags;
  flags_t           flags_next;
  res_word_t        alu_res;

  assign exe_advance = exe_valid && (!res_valid || res_ready);
  assign op_ready    = !exe_valid || exe_advance;
  assign op_accept   = op_valid && op_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      exe_valid <= 1'b0;
    end else if (op_ready) begin
      exe_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op_accept) begin
      exe_word <= op_word;
    end
  end

  eca_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (op_accept),
    .rd_addr_a (op_word.reg_sel),
    .rd_addr_b (op_word.src_sel),
    .rd_data_a (reg_a),
    .rd_data_b (reg_b),
    .wr_en     (exe_advance && alu_res.reg_written),
    .wr_addr   (exe_word.reg_sel),
    .wr_data   (alu_res.result)
  );

  eca_alu u_alu (
    .func       (exe_word.func),
    .a          (reg_a),
    .b          (reg_b),
    .operand    (exe_word.operand),
    .flags      (flags),
    .res        (alu_res),
    .flags_next (flags_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (exe_advance) begin
      flags <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (exe_advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exe_advance) begin
      res_word <= alu_res;
    end
  end

`ifndef SYNTHESIS
  a_flags_match_result: assert property (@(posedge clk) disable iff (rst)
    exe_advance |=> flags.of == res_word.overflow_flag && flags.sf == res_word.sign_flag
                    && flags.zf == res_word.zero_flag)
    else $error("flag register differs from reported flags");
  a_write_or_jump: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_word.reg_written && res_word.jump_taken))
    else $error("word both writes a register and jumps");
  a_exe_holds: assert property (@(posedge clk) disable iff (rst)
    exe_valid && !exe_advance |=> exe_valid && $stable(exe_word))
    else $error("operand stage lost a stalled word");
  a_jump_keeps_flags: assert property (@(posedge clk) disable iff (rst)
    exe_advance && alu_res.jump_taken |=> $stable(flags))
    else $error("jump changed the flags");
`endif

endmodule

`default_nettype wire
